[hw/rtl/trit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trit_pkg: shared types and constants
// Widths, codes and serial-order helpers for the interval tracker.
// ----------------------------------------------------------------------------
package trit_pkg;

  localparam int unsigned MaxIntervals = 16;
  localparam int unsigned IdxW = $clog2(MaxIntervals);
  localparam int unsigned CntW = $clog2(MaxIntervals + 1);
  localparam int unsigned SeqW = 32;
  localparam int unsigned LenW = 25;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [SeqW-1:0] SeqHalf = 32'h7FFF_FFFF;
  localparam logic [LenW-1:0] BufSizeReset = 25'd65536;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StDrop   = 2'd1,
    StBeyond = 2'd2,
    StFull   = 2'd3
  } status_e;

  typedef enum logic {
    OpPut    = 1'b0,
    OpRemove = 1'b1
  } op_e;

  localparam logic [CfgIdxW-1:0] RegBufSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStartSeq = 1'b1;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmScan,
    FsmFix,
    FsmHead,
    FsmOut
  } fsm_e;

  typedef struct packed {
    logic [SeqW-1:0] start;
    logic [LenW-1:0] len;
  } ivl_t;

  // Command broadcast from the controller to every cell for one cycle.
  typedef struct packed {
    logic            scan;     // evaluate join and capture against seg
    logic            commit;   // apply the computed update
    logic            rem;      // remove step
    logic            rem_drop; // remove consumes the whole first interval
    logic [SeqW-1:0] seg_s;
    logic [LenW-1:0] seg_l;
    logic [LenW-1:0] rem_len;
  } cmd_t;

  function automatic logic [SeqW-1:0] seq_lower(input logic [SeqW-1:0] a,
                                                input logic [SeqW-1:0] b);
    logic [SeqW-1:0] r;
    if (a == b) r = a;
    else if (a < b) r = ((b - a) <= SeqHalf) ? a : b;
    else r = ((a - b) <= SeqHalf) ? b : a;
    return r;
  endfunction

  function automatic logic [SeqW-1:0] seq_upper(input logic [SeqW-1:0] a,
                                                input logic [SeqW-1:0] b);
    logic [SeqW-1:0] r;
    if (a == b) r = a;
    else if (a < b) r = ((b - a) <= SeqHalf) ? b : a;
    else r = ((a - b) <= SeqHalf) ? a : b;
    return r;
  endfunction

endpackage

[hw/rtl/trit_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trit_if: valid/ready channel interfaces
// Input, result and configuration channels of the interval tracker.
// ----------------------------------------------------------------------------
interface trit_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [trit_pkg::SeqW-1:0]     seg_seq;
  logic [trit_pkg::LenW-1:0]     amount;
  modport source (output valid, operation, seg_seq, amount, input ready);
  modport sink (input valid, operation, seg_seq, amount, output ready);
endinterface

interface trit_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [trit_pkg::LenW-1:0]     done_len;
  logic [trit_pkg::LenW-1:0]     readable_len;
  logic [trit_pkg::SeqW-1:0]     total_len;
  logic [trit_pkg::SeqW-1:0]     head_sequence;
  modport source (output valid, status, done_len, readable_len, total_len, head_sequence,
                  input ready);
  modport sink (input valid, status, done_len, readable_len, total_len, head_sequence,
                output ready);
endinterface

interface trit_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [trit_pkg::CfgIdxW-1:0]  index;
  logic [trit_pkg::SeqW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/trit_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trit_cell: one interval slot
// Holds one interval, evaluates its join against the segment and shifts
// toward or away from its neighbors on commit and on remove.
// ----------------------------------------------------------------------------
module trit_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  trit_pkg::cmd_t            cmd_i,
  input  logic                      valid_i,      // slot index below count
  input  logic                      head_i,       // this is slot zero
  input  trit_pkg::ivl_t            left_i,       // neighbor at index - 1
  input  trit_pkg::ivl_t            right_i,      // neighbor at index + 1
  input  logic                      shift_in_i,   // insert position below
  input  logic                      ins_here_i,   // segment goes to this slot
  input  logic                      take_union_i, // this slot is first joined
  input  logic [trit_pkg::CntW-1:0] pull_i,       // pull amount (joined minus one)
  input  logic                      pull_sel_i,   // this slot pulls from above
  input  trit_pkg::ivl_t            pull_src_i,   // entry at index + pull
  input  trit_pkg::ivl_t            union_i,
  output trit_pkg::ivl_t            ivl_o,
  output logic                      join_o,
  output logic                      below_o       // start not below segment end
);

  trit_pkg::ivl_t  ivl_q, ivl_d;
  logic            join_q, join_d;
  logic            below_q, below_d;
  logic [trit_pkg::SeqW-1:0] ae, be, end0;

  always_comb begin
    ae   = cmd_i.seg_s + trit_pkg::SeqW'(cmd_i.seg_l) + 32'd1;
    be   = ivl_q.start + trit_pkg::SeqW'(ivl_q.len) + 32'd1;
    end0 = cmd_i.seg_s + trit_pkg::SeqW'(cmd_i.seg_l);
    join_d = join_q;
    below_d = below_q;
    if (cmd_i.scan) begin
      join_d = valid_i &&
               !(trit_pkg::seq_lower(ae, ivl_q.start) == ae ||
                 trit_pkg::seq_lower(be, cmd_i.seg_s) == be);
      below_d = valid_i && (trit_pkg::seq_upper(end0, ivl_q.start) == ivl_q.start);
    end
  end

  // On a remove the whole row shifts down when the first interval is used
  // up; otherwise only slot zero is trimmed from the front.
  always_comb begin
    ivl_d = ivl_q;
    if (cmd_i.commit) begin
      if (take_union_i) ivl_d = union_i;
      else if (pull_sel_i && pull_i != '0) ivl_d = pull_src_i;
      else if (ins_here_i) ivl_d = '{start: cmd_i.seg_s, len: cmd_i.seg_l};
      else if (shift_in_i) ivl_d = left_i;
    end else if (cmd_i.rem) begin
      if (cmd_i.rem_drop) ivl_d = right_i;
      else if (head_i) begin
        ivl_d.start = ivl_q.start + trit_pkg::SeqW'(cmd_i.rem_len);
        ivl_d.len   = ivl_q.len - cmd_i.rem_len;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ivl_q <= ivl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      join_q  <= 1'b0;
      below_q <= 1'b0;
    end else begin
      join_q  <= join_d;
      below_q <= below_d;
    end
  end

  assign ivl_o   = ivl_q;
  assign join_o  = join_q;
  assign below_o = below_q;

endmodule

[hw/rtl/tcp_reassembly_interval_tracker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_reassembly_interval_tracker_core: TCP receive interval tracker
// Keeps the sorted list of received byte ranges in a row of cells and
// reports the contiguous readable run from the head sequence.
// ----------------------------------------------------------------------------
//  Channel   Dir   Carries
//  in_if     in    operation, seg_seq, amount
//  out_if    out   status, done_len, readable_len, total_len, head_sequence
//  cfg_if    in    index, data (0 buffer size, 1 start sequence)
//
// With a ready sink a put passes through cell scan, union, commit, head check,
// result, and the idle state in which the next item is taken. A remove passes
// through scan and update, result settle, result and idle. While the sink holds
// ready low the result waits. The cell scan needs no loop since every cell
// compares itself against the segment at once; the union is formed from the
// first and last joined cells.
// Reset empties the list, clears the head and loads the buffer size reset.
// A result waiting on a stalled sink holds the next item off.
module tcp_reassembly_interval_tracker_core (
  input  logic clk_i,
  input  logic rst_ni,
  trit_in_if.sink    in_if,
  trit_out_if.source out_if,
  trit_cfg_if.sink   cfg_if
);

  localparam int unsigned N = trit_pkg::MaxIntervals;

  trit_pkg::fsm_e state_q, state_d;

  logic [trit_pkg::LenW-1:0] buf_q;
  logic [trit_pkg::SeqW-1:0] head_q, head_d;
  logic [trit_pkg::LenW-1:0] rd_q, rd_d;
  logic [trit_pkg::SeqW-1:0] cum_q, cum_d;
  logic [trit_pkg::CntW-1:0] cnt_q, cnt_d;

  // Item capture.
  logic                      op_q;
  logic [trit_pkg::SeqW-1:0] seq_q;
  logic [trit_pkg::LenW-1:0] amt_q;
  trit_pkg::status_e         st_q, st_d;
  logic [trit_pkg::LenW-1:0] done_q, done_d;

  // Merge results from the fix step.
  trit_pkg::ivl_t            union_q, union_d;
  logic [trit_pkg::IdxW-1:0] first_q, first_d;
  logic [trit_pkg::CntW-1:0] pull_q, pull_d;
  logic                      merged_q, merged_d;
  logic [trit_pkg::CntW-1:0] pos_q, pos_d;

  trit_pkg::cmd_t            cmd;
  trit_pkg::ivl_t            ivl   [N];
  logic                      jn    [N];
  logic                      blw   [N];
  logic [trit_pkg::LenW-1:0] rem_len;

  // Out valid is registered and rises after FsmOut is entered, so the head update lands first.
  logic ov_q;

  assign in_if.ready  = (state_q == trit_pkg::FsmIdle);
  assign cfg_if.ready = 1'b1;

  // Early checks on the captured put.
  logic [trit_pkg::SeqW-1:0] off;
  logic                      is_old, is_beyond;
  always_comb begin
    off       = seq_q - head_q;
    is_old    = trit_pkg::seq_lower(head_q, seq_q) != head_q;
    is_beyond = ({1'b0, off} + 33'(amt_q)) > 33'(buf_q);
  end

  assign rem_len = (rd_q < amt_q) ? rd_q : amt_q;

  always_comb begin
    cmd          = '0;
    cmd.seg_s    = seq_q;
    cmd.seg_l    = amt_q;
    cmd.rem_len  = rem_len;
    cmd.rem_drop = rem_len >= ivl[0].len;
    cmd.scan     = (state_q == trit_pkg::FsmScan) && op_q == trit_pkg::OpPut;
    cmd.commit   = (state_q == trit_pkg::FsmHead) && op_q == trit_pkg::OpPut &&
                   st_q == trit_pkg::StOk;
    cmd.rem      = (state_q == trit_pkg::FsmScan) && op_q == trit_pkg::OpRemove &&
                   rem_len != '0 && cnt_q != '0;
  end

  // Merge reduction: the join flags form one contiguous run in a sorted
  // list, so the union spans from the first joined start to the last
  // joined end. The scan also finds the insert slot when nothing joins.
  always_comb begin
    logic [trit_pkg::SeqW-1:0] lo, hi;
    logic                      seen, stop;
    logic [trit_pkg::IdxW-1:0] last;
    logic [trit_pkg::CntW-1:0] ip;
    trit_pkg::ivl_t            ivl_first, ivl_last;
    seen = 1'b0;
    stop = 1'b0;
    first_d = '0;
    last = '0;
    ip = cnt_q;
    for (int i = 0; i < N; i++) begin
      if (!stop && trit_pkg::CntW'(i) < cnt_q) begin
        if (jn[i]) begin
          if (!seen) first_d = trit_pkg::IdxW'(i);
          seen = 1'b1;
          last = trit_pkg::IdxW'(i);
        end else if (seen || blw[i]) begin
          stop = 1'b1;
          ip = trit_pkg::CntW'(i);
        end
      end
    end
    ivl_first = ivl[first_d];
    ivl_last  = ivl[last];
    lo = trit_pkg::seq_lower(seq_q, ivl_first.start);
    hi = trit_pkg::seq_upper(seq_q + trit_pkg::SeqW'(amt_q),
                             ivl_last.start + trit_pkg::SeqW'(ivl_last.len));
    merged_d = seen;
    union_d.start = lo;
    union_d.len   = trit_pkg::LenW'(hi - lo);
    pull_d = trit_pkg::CntW'(last) - trit_pkg::CntW'(first_d);
    if (cnt_q == '0 ||
        trit_pkg::seq_lower(seq_q, ivl[0].start) == seq_q) pos_d = '0;
    else pos_d = ip;
  end

  // Cell row.
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      trit_pkg::ivl_t left_v, right_v, src_v;
      logic shin, insh, tk, psel;
      always_comb begin
        left_v  = (g == 0) ? '0 : ivl[(g == 0) ? 0 : g - 1];
        right_v = (g == N - 1) ? '0 : ivl[(g == N - 1) ? N - 1 : g + 1];
        src_v = '0;
        for (int k = 0; k < N; k++) begin
          if (trit_pkg::CntW'(k) == trit_pkg::CntW'(g) + pull_q) src_v = ivl[k];
        end
        tk   = merged_q && trit_pkg::IdxW'(g) == first_q;
        psel = merged_q && trit_pkg::CntW'(g) > trit_pkg::CntW'(first_q);
        insh = !merged_q && trit_pkg::CntW'(g) == pos_q;
        shin = !merged_q && trit_pkg::CntW'(g) > pos_q;
      end
      trit_cell u_cell (
        .clk_i, .rst_ni,
        .cmd_i        (cmd),
        .valid_i      (trit_pkg::CntW'(g) < cnt_q),
        .head_i       (g == 0),
        .left_i       (left_v),
        .right_i      (right_v),
        .shift_in_i   (shin),
        .ins_here_i   (insh),
        .take_union_i (tk),
        .pull_i       (pull_q),
        .pull_sel_i   (psel),
        .pull_src_i   (src_v),
        .union_i      (union_q),
        .ivl_o        (ivl[g]),
        .join_o       (jn[g]),
        .below_o      (blw[g])
      );
    end
  endgenerate

  // Next state. FsmOut settles the head check before the result is offered.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trit_pkg::FsmIdle: if (in_if.valid) state_d = trit_pkg::FsmScan;
      trit_pkg::FsmScan: state_d = (op_q == trit_pkg::OpPut) ? trit_pkg::FsmFix
                                                             : trit_pkg::FsmOut;
      trit_pkg::FsmFix:  state_d = trit_pkg::FsmHead;
      trit_pkg::FsmHead: state_d = trit_pkg::FsmOut;
      trit_pkg::FsmOut:  if (ov_q && out_if.ready) state_d = trit_pkg::FsmIdle;
      default:           state_d = trit_pkg::FsmIdle;
    endcase
  end

  // Datapath updates.
  always_comb begin
    head_d = head_q;
    rd_d   = rd_q;
    cum_d  = cum_q;
    cnt_d  = cnt_q;
    st_d   = st_q;
    done_d = done_q;
    unique case (state_q)
      trit_pkg::FsmScan: begin
        if (op_q == trit_pkg::OpRemove) begin
          st_d = trit_pkg::StOk;
          done_d = rem_len;
          if (rem_len != '0) begin
            head_d = head_q + trit_pkg::SeqW'(rem_len);
            rd_d = rd_q - rem_len;
            if (cnt_q != '0 && cmd.rem_drop) cnt_d = cnt_q - 1'b1;
          end
        end else begin
          done_d = '0;
          if (amt_q == '0 || is_old) st_d = trit_pkg::StDrop;
          else if (is_beyond) st_d = trit_pkg::StBeyond;
          else st_d = trit_pkg::StOk;
        end
      end
      trit_pkg::FsmFix: begin
        if (st_q == trit_pkg::StOk && !merged_d && cnt_q >= trit_pkg::CntW'(N))
          st_d = trit_pkg::StFull;
      end
      trit_pkg::FsmHead: begin
        if (st_q == trit_pkg::StOk) begin
          done_d = amt_q;
          if (merged_q) cnt_d = cnt_q - pull_q;
          else cnt_d = cnt_q + 1'b1;
        end
      end
      trit_pkg::FsmOut: begin
        // Head check after the commit, on the settled list.
        if (op_q == trit_pkg::OpPut && st_q == trit_pkg::StOk && cnt_q != '0 &&
            head_q == ivl[0].start && !ov_q) begin
          cum_d = cum_q + trit_pkg::SeqW'(ivl[0].len) - trit_pkg::SeqW'(rd_q);
          rd_d  = ivl[0].len;
        end
      end
      default: ;
    endcase
    if (cfg_if.valid && cfg_if.index == trit_pkg::RegStartSeq) head_d = cfg_if.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trit_pkg::FsmIdle;
      buf_q   <= trit_pkg::BufSizeReset;
      head_q  <= '0;
      rd_q    <= '0;
      cum_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      rd_q   <= rd_d;
      cum_q  <= cum_d;
      cnt_q  <= cnt_d;
      if (state_q == trit_pkg::FsmOut && !ov_q) ov_q <= 1'b1;
      else if (ov_q && out_if.ready) ov_q <= 1'b0;
      if (cfg_if.valid && cfg_if.index == trit_pkg::RegBufSize)
        buf_q <= cfg_if.data[trit_pkg::LenW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      op_q  <= in_if.operation;
      seq_q <= in_if.seg_seq;
      amt_q <= in_if.amount;
    end
    st_q   <= st_d;
    done_q <= done_d;
    if (state_q == trit_pkg::FsmFix) begin
      union_q  <= union_d;
      first_q  <= first_d;
      pull_q   <= pull_d;
      merged_q <= merged_d;
      pos_q    <= pos_d;
    end
  end

  assign out_if.valid         = ov_q;
  assign out_if.status        = st_q;
  assign out_if.done_len      = done_q;
  assign out_if.readable_len  = rd_q;
  assign out_if.total_len     = cum_q;
  assign out_if.head_sequence = head_q;

endmodule

[hw/rtl/trit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trit_checker: port-level checks
// Watches the channels of the interval tracker over time.
// ----------------------------------------------------------------------------
module trit_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [1:0] status_i,
  input logic [trit_pkg::LenW-1:0] done_len_i
);

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result dropped under stall");

  a_fail_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != trit_pkg::StOk |-> done_len_i == '0)
    else $error("refused put reports bytes");

endmodule

bind tcp_reassembly_interval_tracker_core trit_checker u_trit_checker (
  .clk_i, .rst_ni,
  .in_valid_i (in_if.valid), .in_ready_i (in_if.ready),
  .out_valid_i (out_if.valid), .out_ready_i (out_if.ready),
  .status_i (out_if.status), .done_len_i (out_if.done_len)
);
